>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked checks, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every rising clk edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a rising clk edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

>>> rtl/lss_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lss_pkg
// shared types and register codes of the largest empty square search unit
// ---------------------------------------------------------------------------
package lss_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OBSTACLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT   = 2'd2;

    // per-cell flags handed from the scan stage to the recurrence stage
    typedef struct packed {
        logic free;
        logic first_row;
        logic first_col;
        logic end_map;
    } lss_ctl_t;

endpackage

>>> rtl/lss_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lss_ram
// simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module lss_ram #(
    parameter int DATA_W = 11,
    parameter int DEPTH  = 1024
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [DATA_W-1:0]                       wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [DATA_W-1:0]                       rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/lss_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lss_scan
// input stage: tracks the map position, issues the row buffer read and
// hands each item to the recurrence stage
// ---------------------------------------------------------------------------
module lss_scan #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 65536
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_stall,
    input  logic [7:0]                                      cell_char,
    input  logic [7:0]                                      obstacle_char,
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]                eff_width,
    input  logic [$clog2(MAX_HEIGHT + 1)-1:0]               eff_height,
    input  logic                                            s1_ready,
    output logic                                            rd_en,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   rd_addr,
    output logic                                            s1_valid,
    output lss_pkg::lss_ctl_t                               s1_ctl,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   s1_col,
    output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] s1_row
);

    import lss_pkg::*;

    localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);

    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic                s1_valid_reg, s1_valid_next;
    lss_ctl_t            s1_ctl_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic [ROW_W-1:0]    s1_row_reg;

    logic                accept;
    logic                end_row;
    logic                end_map;
    logic [WIDTH_W-1:0]  col_inc;
    logic [HEIGHT_W-1:0] row_inc;
    lss_ctl_t            ctl;

    assign in_stall = s1_valid_reg && !s1_ready;
    assign accept   = in_valid && !in_stall;
    assign rd_en    = accept;
    assign rd_addr  = cur_col_reg;

    always_comb
    begin
        col_inc = WIDTH_W'(cur_col_reg) + WIDTH_W'(1);
        row_inc = HEIGHT_W'(cur_row_reg) + HEIGHT_W'(1);
        end_row = (col_inc >= eff_width);
        end_map = end_row && (row_inc >= eff_height);

        ctl.free      = (cell_char != obstacle_char);
        ctl.first_row = (cur_row_reg == '0);
        ctl.first_col = (cur_col_reg == '0);
        ctl.end_map   = end_map;

        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (accept)
        begin
            if (end_map)
            begin
                cur_col_next = '0;
                cur_row_next = '0;
            end
            else if (end_row)
            begin
                cur_col_next = '0;
                cur_row_next = row_inc[ROW_W-1:0];
            end
            else
            begin
                cur_col_next = col_inc[COL_W-1:0];
            end
        end

        // the stage drains when the recurrence takes its item
        s1_valid_next = accept || (s1_valid_reg && !s1_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg <= ctl;
            s1_col_reg <= cur_col_reg;
            s1_row_reg <= cur_row_reg;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_ctl   = s1_ctl_reg;
    assign s1_col   = s1_col_reg;
    assign s1_row   = s1_row_reg;

endmodule

>>> rtl/lss_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lss_core
// recurrence stage: min of up, left and up-left plus one (zero on an obstacle),
// row buffer write back, best square tracking and the result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lss_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 65536
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            s1_valid,
    input  lss_pkg::lss_ctl_t                               s1_ctl,
    input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   s1_col,
    input  logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] s1_row,
    output logic                                            s1_ready,
    input  logic                                            rd_en,
    input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   rd_addr,
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]                rd_data,
    output logic                                            wr_en,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   wr_addr,
    output logic [$clog2(MAX_WIDTH + 1)-1:0]                wr_data,
    output logic                                            out_valid,
    input  logic                                            out_stall,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   square_col,
    output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] square_row,
    output logic [$clog2(MAX_WIDTH + 1)-1:0]                square_size
);

    import lss_pkg::*;

    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SIZE_W  = $clog2(MAX_WIDTH + 1);
    localparam int CCALC_W = ((COL_W > SIZE_W) ? COL_W : SIZE_W) + 1;
    localparam int RCALC_W = ((ROW_W > SIZE_W) ? ROW_W : SIZE_W) + 1;

    logic [SIZE_W-1:0]  left_size_reg, left_size_next;
    logic [SIZE_W-1:0]  diag_size_reg, diag_size_next;
    logic [SIZE_W-1:0]  best_size_reg, best_size_next;
    logic [COL_W-1:0]   best_col_reg, best_col_next;
    logic [ROW_W-1:0]   best_row_reg, best_row_next;
    logic               fwd_valid_reg;
    logic [SIZE_W-1:0]  fwd_data_reg;
    logic               out_valid_reg, out_valid_next;
    logic [COL_W-1:0]   out_col_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [SIZE_W-1:0]  out_size_reg;

    logic               fire;
    logic               load_out;
    logic [SIZE_W-1:0]  up;
    logic [SIZE_W-1:0]  left;
    logic [SIZE_W-1:0]  diag;
    logic [SIZE_W-1:0]  min_size;
    logic [SIZE_W-1:0]  s_val;
    logic [CCALC_W-1:0] col_calc;
    logic [RCALC_W-1:0] row_calc;

    // a finishing item waits only while the previous result is still held
    assign s1_ready = !(s1_ctl.end_map && out_valid_reg && out_stall);
    assign fire     = s1_valid && s1_ready;
    assign load_out = fire && s1_ctl.end_map;

    always_comb
    begin
        // the row buffer entry is ignored on the first row
        if (s1_ctl.first_row)
        begin
            up = '0;
        end
        else if (fwd_valid_reg)
        begin
            up = fwd_data_reg;
        end
        else
        begin
            up = rd_data;
        end
        left = s1_ctl.first_col ? '0 : left_size_reg;
        diag = (s1_ctl.first_row || s1_ctl.first_col) ? '0 : diag_size_reg;

        min_size = up;
        if (left < min_size)
        begin
            min_size = left;
        end
        if (diag < min_size)
        begin
            min_size = diag;
        end
        s_val = s1_ctl.free ? (min_size + SIZE_W'(1)) : '0;

        col_calc = CCALC_W'(s1_col) + CCALC_W'(1) - CCALC_W'(s_val);
        row_calc = RCALC_W'(s1_row) + RCALC_W'(1) - RCALC_W'(s_val);

        best_size_next = best_size_reg;
        best_col_next  = best_col_reg;
        best_row_next  = best_row_reg;
        if (s_val > best_size_reg)
        begin
            best_size_next = s_val;
            best_col_next  = col_calc[COL_W-1:0];
            best_row_next  = row_calc[ROW_W-1:0];
        end

        left_size_next = s_val;
        diag_size_next = up;

        out_valid_next = load_out || (out_valid_reg && out_stall);
    end

    assign wr_en   = fire;
    assign wr_addr = s1_col;
    assign wr_data = s_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_size_reg <= '0;
            diag_size_reg <= '0;
            best_size_reg <= '0;
            best_col_reg  <= '0;
            best_row_reg  <= '0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            // same-entry read and write in one cycle: take the new size
            if (rd_en)
            begin
                fwd_valid_reg <= wr_en && (wr_addr == rd_addr);
            end
            if (fire)
            begin
                if (s1_ctl.end_map)
                begin
                    left_size_reg <= '0;
                    diag_size_reg <= '0;
                    best_size_reg <= '0;
                    best_col_reg  <= '0;
                    best_row_reg  <= '0;
                end
                else
                begin
                    left_size_reg <= left_size_next;
                    diag_size_reg <= diag_size_next;
                    best_size_reg <= best_size_next;
                    best_col_reg  <= best_col_next;
                    best_row_reg  <= best_row_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_data_reg <= s_val;
        end
        if (load_out)
        begin
            out_col_reg  <= best_col_next;
            out_row_reg  <= best_row_next;
            out_size_reg <= best_size_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign square_col  = out_col_reg;
    assign square_row  = out_row_reg;
    assign square_size = out_size_reg;

    `ASSERT_NEVER(a_out_overwrite, load_out && out_valid_reg && out_stall, "result overwritten")
    `ASSERT_CLK(a_size_bound, !fire || (SIZE_W'(s1_col) + SIZE_W'(1) >= s_val), "size exceeds column")
    `ASSERT_CLK(a_best_grows, (fire && !s1_ctl.end_map) |=> (best_size_reg >= $past(best_size_reg)), "best size shrank")
    `ASSERT_NEVER(a_fwd_first_row, fire && fwd_valid_reg && s1_ctl.first_row && up != '0, "row buffer used on first row")

endmodule

>>> rtl/largest_empty_square_search_unit.sv
`timescale 1ns / 1ps
// a result is valid once the last cell of the map has passed the scan stage and result registers
// throughput: one cell per cycle, one row buffer read and one write per cell
// a cell stalls only while a finished map waits on a result still held at the output
// reset clears position, best square and valid flags; the row buffer and data registers are not cleared
// ---------------------------------------------------------------------------
// largest_empty_square_search_unit
// streams map characters row by row and reports the largest obstacle-free
// square after the last cell, using a one-row size buffer
// ---------------------------------------------------------------------------
module largest_empty_square_search_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 65536
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_stall,
    input  logic [7:0]                                      cell_char,
    output logic                                            out_valid,
    input  logic                                            out_stall,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   square_col,
    output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] square_row,
    output logic [$clog2(MAX_WIDTH + 1)-1:0]                square_size,
    input  logic                                            cfg_valid,
    output logic                                            cfg_ready,
    input  logic [lss_pkg::CFG_IDX_W-1:0]                   cfg_index,
    input  logic [(($clog2(MAX_HEIGHT + 1) > $clog2(MAX_WIDTH + 1)) ?
                   (($clog2(MAX_HEIGHT + 1) > 8) ? $clog2(MAX_HEIGHT + 1) : 8) :
                   (($clog2(MAX_WIDTH + 1) > 8) ? $clog2(MAX_WIDTH + 1) : 8))-1:0] cfg_data
);

    import lss_pkg::*;

    localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
    localparam int RST_WIDTH = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

    logic [7:0]          obstacle_reg, obstacle_next;
    logic [WIDTH_W-1:0]  eff_width_reg, eff_width_next;
    logic [HEIGHT_W-1:0] eff_height_reg, eff_height_next;

    logic                cfg_write;
    logic [WIDTH_W-1:0]  wdata;
    logic [HEIGHT_W-1:0] hdata;

    logic                rd_en;
    logic [COL_W-1:0]    rd_addr;
    logic [WIDTH_W-1:0]  rd_data;
    logic                wr_en;
    logic [COL_W-1:0]    wr_addr;
    logic [WIDTH_W-1:0]  wr_data;
    logic                s1_valid;
    logic                s1_ready;
    lss_ctl_t            s1_ctl;
    logic [COL_W-1:0]    s1_col;
    logic [ROW_W-1:0]    s1_row;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign wdata     = cfg_data[WIDTH_W-1:0];
    assign hdata     = cfg_data[HEIGHT_W-1:0];

    // width and height are stored already clamped to their legal range
    always_comb
    begin
        obstacle_next   = obstacle_reg;
        eff_width_next  = eff_width_reg;
        eff_height_next = eff_height_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_IDX_OBSTACLE:
                begin
                    obstacle_next = cfg_data[7:0];
                end
                CFG_IDX_WIDTH:
                begin
                    if (wdata == '0)
                    begin
                        eff_width_next = WIDTH_W'(1);
                    end
                    else if (wdata > WIDTH_W'(MAX_WIDTH))
                    begin
                        eff_width_next = WIDTH_W'(MAX_WIDTH);
                    end
                    else
                    begin
                        eff_width_next = wdata;
                    end
                end
                CFG_IDX_HEIGHT:
                begin
                    if (hdata == '0)
                    begin
                        eff_height_next = HEIGHT_W'(1);
                    end
                    else if (hdata > HEIGHT_W'(MAX_HEIGHT))
                    begin
                        eff_height_next = HEIGHT_W'(MAX_HEIGHT);
                    end
                    else
                    begin
                        eff_height_next = hdata;
                    end
                end
                default:
                begin
                    obstacle_next = obstacle_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obstacle_reg   <= '0;
            eff_width_reg  <= WIDTH_W'(RST_WIDTH);
            eff_height_reg <= HEIGHT_W'(1);
        end
        else
        begin
            obstacle_reg   <= obstacle_next;
            eff_width_reg  <= eff_width_next;
            eff_height_reg <= eff_height_next;
        end
    end

    lss_ram #(
        .DATA_W (WIDTH_W),
        .DEPTH  (MAX_WIDTH)
    ) u_row_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lss_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cell_char     (cell_char),
        .obstacle_char (obstacle_reg),
        .eff_width     (eff_width_reg),
        .eff_height    (eff_height_reg),
        .s1_ready      (s1_ready),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .s1_valid      (s1_valid),
        .s1_ctl        (s1_ctl),
        .s1_col        (s1_col),
        .s1_row        (s1_row)
    );

    lss_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .s1_valid    (s1_valid),
        .s1_ctl      (s1_ctl),
        .s1_col      (s1_col),
        .s1_row      (s1_row),
        .s1_ready    (s1_ready),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .square_col  (square_col),
        .square_row  (square_row),
        .square_size (square_size)
    );

endmodule
